// File: design/dedge_pkg.sv
// Shared types and constants for the depth edge reject filter.
// Depends on nothing; used by depth_edge_reject_filter.
`timescale 1ns / 1ps

package dedge_pkg;

   // Fixed field widths
   localparam int DEPTH_BITS = 16;
   localparam int GEOM_BITS  = 12;
   localparam int COORD_BITS = 11;
   localparam int MINN_BITS  = 4;
   localparam int CSR_ADDR_BITS = 3;

   // Geometry limits
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAX_HEIGHT    = 2048;

   // Register reset values
   localparam logic [DEPTH_BITS-1:0] DEPTH_MIN_RST  = 16'd100;
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX_RST  = 16'd10000;
   localparam logic [DEPTH_BITS-1:0] EDGE_DELTA_RST = 16'd0;
   localparam logic [DEPTH_BITS-1:0] EDGE_RATIO_RST = 16'd0;
   localparam logic [MINN_BITS-1:0]  EDGE_MINN_RST  = 4'd0;
   localparam logic [GEOM_BITS-1:0]  WIDTH_RST      = 12'd640;
   localparam logic [GEOM_BITS-1:0]  HEIGHT_RST     = 12'd480;

   // Register indexes on the csr port
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_DEPTH_MIN    = 3'd0,
      REG_DEPTH_MAX    = 3'd1,
      REG_EDGE_DELTA   = 3'd2,
      REG_EDGE_RATIO   = 3'd3,
      REG_EDGE_MINN    = 3'd4,
      REG_IMAGE_WIDTH  = 3'd5,
      REG_IMAGE_HEIGHT = 3'd6
   } reg_index_type;

   // Result codes
   typedef enum logic [1:0] {
      VERDICT_KEPT    = 2'd0,
      VERDICT_INVALID = 2'd1,
      VERDICT_EDGE    = 2'd2
   } verdict_type;

   // Per-pixel bookkeeping that travels down the pipeline
   typedef struct packed {
      logic                  have;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  frame_end;
      logic                  at_left;
      logic                  at_right;
      logic                  at_top;
      logic                  at_bottom;
   } meta_type;

   // Depth inside the accepted range and nonzero
   function automatic logic depth_ok(input logic [DEPTH_BITS-1:0] z,
                                     input logic [DEPTH_BITS-1:0] zmin,
                                     input logic [DEPTH_BITS-1:0] zmax);
      depth_ok = (z != '0) && (z >= zmin) && (z <= zmax);
   endfunction

endpackage

// File: design/depth_edge_reject_filter.sv
// Top level of the 3x3 depth edge reject filter: line memories, window,
// judging pipeline and result register. Depends on dedge_pkg.
`timescale 1ns / 1ps

// Depth pixels enter in raster order, one request per clock, and each pixel
// leaves with a verdict (kept, invalid depth, or rejected as a depth edge)
// once the pixel one row and one column later has arrived, so the host sends
// image_width + 1 flush requests after every frame. The block sustains one
// request per clock whenever rsp_tready stays high; a result passes stages 1
// to 4 and then the result register. The throughput is set by the two line
// memories, each read once and written once per request with a registered
// read; a write-to-read forwarding path covers back-to-back requests on the
// same column. The line memories need no clearing pass after reset.
// Configuration must only be written while the pipeline is empty.
module depth_edge_reject_filter #(
   parameter int MAX_WIDTH = dedge_pkg::MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] depth_mm
   input  logic [0:0]  req_tuser,   // [0] cmd (1 = flush tick)
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] verdict, [17:2] center_depth_mm,
                                    // [28:18] pixel_x, [39:29] pixel_y
   output logic        rsp_tlast,   // frame_end
   // configuration
   input  logic        csr_we,
   input  logic [dedge_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int DB = dedge_pkg::DEPTH_BITS;
   localparam int GB = dedge_pkg::GEOM_BITS;
   localparam int CB = dedge_pkg::COORD_BITS;
   localparam int NB = dedge_pkg::MINN_BITS;

   // ---------------------------------------------------------------------
   // Configuration registers
   logic [DB-1:0] depth_min_ff, depth_max_ff, edge_delta_ff, edge_ratio_ff;
   logic [NB-1:0] edge_minn_ff;
   logic [GB-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_min_ff  <= dedge_pkg::DEPTH_MIN_RST;
         depth_max_ff  <= dedge_pkg::DEPTH_MAX_RST;
         edge_delta_ff <= dedge_pkg::EDGE_DELTA_RST;
         edge_ratio_ff <= dedge_pkg::EDGE_RATIO_RST;
         edge_minn_ff  <= dedge_pkg::EDGE_MINN_RST;
         width_ff      <= dedge_pkg::WIDTH_RST;
         height_ff     <= dedge_pkg::HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            dedge_pkg::REG_DEPTH_MIN:    depth_min_ff  <= csr_wdata;
            dedge_pkg::REG_DEPTH_MAX:    depth_max_ff  <= csr_wdata;
            dedge_pkg::REG_EDGE_DELTA:   edge_delta_ff <= csr_wdata;
            dedge_pkg::REG_EDGE_RATIO:   edge_ratio_ff <= csr_wdata;
            dedge_pkg::REG_EDGE_MINN:    edge_minn_ff  <= csr_wdata[NB-1:0];
            dedge_pkg::REG_IMAGE_WIDTH:  width_ff      <= csr_wdata[GB-1:0];
            dedge_pkg::REG_IMAGE_HEIGHT: height_ff     <= csr_wdata[GB-1:0];
            default: ;
         endcase
      end
   end

   // Saturated geometry
   logic [WW-1:0] w_eff;
   logic [GB-1:0] h_eff;

   always_comb begin
      if (width_ff < 12'd2)                         w_eff = WW'(2);
      else if (32'(width_ff) > 32'(MAX_WIDTH))      w_eff = WW'(MAX_WIDTH);
      else                                          w_eff = WW'(width_ff);
      if (height_ff < 12'd2)                        h_eff = GB'(2);
      else if (32'(height_ff) > dedge_pkg::MAX_HEIGHT) h_eff = GB'(dedge_pkg::MAX_HEIGHT);
      else                                          h_eff = height_ff;
   end

   // ---------------------------------------------------------------------
   // Pipeline advance: everything moves when the result register is empty or being taken
   logic adv;
   logic accept;
   logic rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   // ---------------------------------------------------------------------
   // Raster position of the incoming request
   logic [AW-1:0] col_ff, col_in;
   logic [GB-1:0] row_ff, row_in;
   logic [AW-1:0] c0;
   logic [GB-1:0] r0;
   logic [WW-1:0] x_full, c1;
   logic [GB-1:0] y0;
   logic          wrap_pre;
   dedge_pkg::meta_type meta0;
   logic [DB-1:0] z0;

   always_comb begin
      wrap_pre = WW'(col_ff) >= w_eff;
      c0 = wrap_pre ? '0 : col_ff;
      r0 = wrap_pre ? row_ff + 1'b1 : row_ff;

      // position of the pixel judged by this request
      if (c0 != '0) begin
         x_full     = WW'(c0) - 1'b1;
         y0         = r0 - 1'b1;
         meta0.have = (r0 != '0);
      end else begin
         x_full     = w_eff - 1'b1;
         y0         = r0 - 2'd2;
         meta0.have = (r0 >= 12'd2);
      end
      meta0.have      = meta0.have && (y0 < h_eff);
      meta0.x         = CB'(x_full);
      meta0.y         = CB'(y0);
      meta0.at_left   = (x_full == '0);
      meta0.at_right  = (x_full == w_eff - 1'b1);
      meta0.at_top    = (y0 == '0);
      meta0.at_bottom = (y0 == h_eff - 1'b1);
      meta0.frame_end = meta0.at_right && meta0.at_bottom;

      // next position
      c1 = WW'(c0) + 1'b1;
      if (r0 >= h_eff + 1'b1) begin
         col_in = '0;
         row_in = '0;
      end else if (c1 >= w_eff) begin
         col_in = '0;
         row_in = r0 + 1'b1;
      end else begin
         col_in = c1[AW-1:0];
         row_in = r0;
      end

      z0 = req_tuser[0] ? '0 : req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: line memory read issued, bookkeeping registered
   logic                v1_ff;
   logic [AW-1:0]       addr1_ff;
   logic [DB-1:0]       z1_ff;
   dedge_pkg::meta_type meta1_ff;
   logic [DB-1:0]       rd_a_ff, rd_b_ff;
   logic                fwd_ff;
   logic [DB-1:0]       fwd_a_ff, fwd_b_ff;
   logic [DB-1:0]       up1, up2;
   logic                mem_we;

   logic [DB-1:0] line_a [MAX_WIDTH];
   logic [DB-1:0] line_b [MAX_WIDTH];

   // data of the previous row and of the row before it, with forwarding
   assign up1    = fwd_ff ? fwd_a_ff : rd_a_ff;
   assign up2    = fwd_ff ? fwd_b_ff : rd_b_ff;
   assign mem_we = adv && v1_ff;

   // line memory of the previous row
   always_ff @(posedge clock) begin
      if (mem_we) line_a[addr1_ff] <= z1_ff;
      if (adv)    rd_a_ff <= line_a[c0];
   end

   // line memory of the row before that
   always_ff @(posedge clock) begin
      if (mem_we) line_b[addr1_ff] <= up1;
      if (adv)    rd_b_ff <= line_b[c0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= req_tvalid;
         fwd_ff <= v1_ff && (addr1_ff == c0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         addr1_ff <= c0;
         z1_ff    <= z0;
         meta1_ff <= meta0;
         fwd_a_ff <= z1_ff;
         fwd_b_ff <= up1;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: 3x3 window shift
   logic                v2_ff;
   dedge_pkg::meta_type meta2_ff;
   logic [DB-1:0]       window_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         for (int k = 0; k < 9; k++) window_ff[k] <= '0;
      end else if (adv) begin
         v2_ff <= v1_ff;
         if (v1_ff) begin
            for (int k = 0; k < 3; k++) begin
               window_ff[k*3]   <= window_ff[k*3+1];
               window_ff[k*3+1] <= window_ff[k*3+2];
            end
            window_ff[2] <= up2;
            window_ff[5] <= up1;
            window_ff[8] <= z1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) meta2_ff <= meta1_ff;
   end

   // Neighbor masks and relative threshold product
   logic [8:0]      mask2;
   logic [2*DB-1:0] prod2;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         mask2[k] = dedge_pkg::depth_ok(window_ff[k], depth_min_ff, depth_max_ff)
                    && !((k < 3) && meta2_ff.at_top)
                    && !((k > 5) && meta2_ff.at_bottom)
                    && !((k % 3 == 0) && meta2_ff.at_left)
                    && !((k % 3 == 2) && meta2_ff.at_right);
      end
      mask2[4] = 1'b1;
      prod2 = edge_ratio_ff * window_ff[4];
   end

   // ---------------------------------------------------------------------
   // Stage 3: masked window, center validity and product registered
   logic                v3_ff;
   dedge_pkg::meta_type meta3_ff;
   logic [DB-1:0]       win3_ff [9];
   logic [8:0]          mask3_ff;
   logic                cok3_ff;
   logic [2*DB-1:0]     prod3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta3_ff <= meta2_ff;
         for (int k = 0; k < 9; k++) win3_ff[k] <= window_ff[k];
         mask3_ff <= mask2;
         cok3_ff  <= dedge_pkg::depth_ok(window_ff[4], depth_min_ff, depth_max_ff);
         prod3_ff <= prod2;
      end
   end

   // Min, max and count over the valid window members
   logic [DB-1:0] zmin3, zmax3;
   logic [NB-1:0] cnt3;

   always_comb begin
      zmin3 = win3_ff[4];
      zmax3 = win3_ff[4];
      cnt3  = '0;
      for (int k = 0; k < 9; k++) begin
         if (mask3_ff[k]) begin
            if (win3_ff[k] < zmin3) zmin3 = win3_ff[k];
            if (win3_ff[k] > zmax3) zmax3 = win3_ff[k];
            cnt3 = cnt3 + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: statistics registered
   logic                v4_ff;
   dedge_pkg::meta_type meta4_ff;
   logic [DB-1:0]       zmin4_ff, zmax4_ff, center4_ff;
   logic [NB-1:0]       cnt4_ff;
   logic                cok4_ff;
   logic [2*DB-1:0]     prod4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta4_ff   <= meta3_ff;
         zmin4_ff   <= zmin3;
         zmax4_ff   <= zmax3;
         center4_ff <= win3_ff[4];
         cnt4_ff    <= cnt3;
         cok4_ff    <= cok3_ff;
         prod4_ff   <= prod3_ff;
      end
   end

   // Edge decision
   logic [DB-1:0]          spread4;
   logic                   reject4;
   dedge_pkg::verdict_type verdict_in;

   always_comb begin
      spread4 = zmax4_ff - zmin4_ff;
      reject4 = !((edge_delta_ff == '0) && (edge_ratio_ff == '0))
                && (edge_minn_ff != '0) && (cnt4_ff >= edge_minn_ff)
                && (spread4 > edge_delta_ff)
                && ({spread4, {DB{1'b0}}} > prod4_ff);
      if (!cok4_ff)     verdict_in = dedge_pkg::VERDICT_INVALID;
      else if (reject4) verdict_in = dedge_pkg::VERDICT_EDGE;
      else              verdict_in = dedge_pkg::VERDICT_KEPT;
   end

   // ---------------------------------------------------------------------
   // Result register
   dedge_pkg::verdict_type verdict_ff;
   logic [DB-1:0]          center_ff;
   logic [CB-1:0]          px_ff, py_ff;
   logic                   frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= v4_ff && meta4_ff.have;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         verdict_ff   <= verdict_in;
         center_ff    <= center4_ff;
         px_ff        <= meta4_ff.x;
         py_ff        <= meta4_ff.y;
         frame_end_ff <= meta4_ff.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {py_ff, px_ff, center_ff, verdict_ff};
   assign rsp_tlast  = frame_end_ff;

endmodule

// File: sim/tb_top.sv
// Self-checking bench for depth_edge_reject_filter: streams raster depth frames
// plus flush ticks, predicts each verdict with a line-buffer model, compares.
// Depends on dedge_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_REQS  = 650;
   localparam int CALM_AFTER   = 500;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic        flush;
      logic [15:0] depth;
   } depth_req_type;

   typedef struct packed {
      dedge_pkg::verdict_type           verdict;
      logic [15:0]                      depth;
      logic [dedge_pkg::COORD_BITS-1:0] x;
      logic [dedge_pkg::COORD_BITS-1:0] y;
      logic                             last;
   } pixel_verdict_type;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [15:0]                         req_tdata  = '0;   // [15:0] depth_mm
   logic [0:0]                          req_tuser  = '0;   // [0] cmd (1 = flush tick)
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [39:0]                         rsp_tdata;         // [1:0] verdict, [17:2] depth,
                                                           // [28:18] x, [39:29] y
   logic                                rsp_tlast;         // frame_end
   logic                                csr_we     = 1'b0;
   logic [dedge_pkg::CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [15:0]                         csr_wdata  = '0;

   depth_edge_reject_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the filter: registers, line stores, window, raster position
   logic [15:0]                     cfg_min    = dedge_pkg::DEPTH_MIN_RST;
   logic [15:0]                     cfg_max    = dedge_pkg::DEPTH_MAX_RST;
   logic [15:0]                     cfg_delta  = dedge_pkg::EDGE_DELTA_RST;
   logic [15:0]                     cfg_ratio  = dedge_pkg::EDGE_RATIO_RST;
   logic [dedge_pkg::MINN_BITS-1:0] cfg_minn   = dedge_pkg::EDGE_MINN_RST;
   logic [dedge_pkg::GEOM_BITS-1:0] cfg_width  = dedge_pkg::WIDTH_RST;
   logic [dedge_pkg::GEOM_BITS-1:0] cfg_height = dedge_pkg::HEIGHT_RST;
   logic [15:0]                     line_a [dedge_pkg::MAX_WIDTH_DEF];
   logic [15:0]                     line_b [dedge_pkg::MAX_WIDTH_DEF];
   logic [15:0]                     win [9];
   int                              pos_col = 0;
   int                              pos_row = 0;

   depth_req_type     pending_px [$];
   pixel_verdict_type verdicts_due [$];
   int                n_pushed    = 0;
   int                n_accepted  = 0;
   int                n_bad       = 0;
   int                cycle_count = 0;
   int                surf_base   = 1500;
   bit                idle_on     = 1'b1;
   bit                hold_req    = 1'b0;

   function automatic int eff_width();
      if (cfg_width < 2) return 2;
      if (cfg_width > dedge_pkg::MAX_WIDTH_DEF) return dedge_pkg::MAX_WIDTH_DEF;
      return int'(cfg_width);
   endfunction

   function automatic int eff_height();
      if (cfg_height < 2) return 2;
      if (cfg_height > dedge_pkg::MAX_HEIGHT) return dedge_pkg::MAX_HEIGHT;
      return int'(cfg_height);
   endfunction

   function automatic bit depth_valid(logic [15:0] z);
      return z != 0 && z >= cfg_min && z <= cfg_max;
   endfunction

   // Verdict for the window center; neighbors outside the image are skipped
   function automatic dedge_pkg::verdict_type judge_window(int x, int y, int w, int h);
      logic [15:0]     zc, v, zlo, zhi;
      int              n;
      longint unsigned spread;
      zc = win[4];
      zlo = zc;
      zhi = zc;
      n = 1;
      if (!depth_valid(zc)) return dedge_pkg::VERDICT_INVALID;
      for (int dr = 0; dr < 3; dr++) begin
         for (int dc = 0; dc < 3; dc++) begin
            v = win[dr*3 + dc];
            if (!(dr == 1 && dc == 1) && !(dr == 0 && y == 0) && !(dr == 2 && y == h - 1)
                && !(dc == 0 && x == 0) && !(dc == 2 && x == w - 1) && depth_valid(v)) begin
               if (v < zlo) zlo = v;
               if (v > zhi) zhi = v;
               n++;
            end
         end
      end
      if (cfg_delta == 0 && cfg_ratio == 0) return dedge_pkg::VERDICT_KEPT;
      if (cfg_minn == 0 || n < cfg_minn) return dedge_pkg::VERDICT_KEPT;
      spread = zhi - zlo;
      // exact compare of spread against ratio * depth in Q16
      if (spread > cfg_delta && (spread << 16) > longint'(cfg_ratio) * longint'(zc))
         return dedge_pkg::VERDICT_EDGE;
      return dedge_pkg::VERDICT_KEPT;
   endfunction

   // Advance the shadow by one accepted request and queue any verdict it yields
   function automatic void filter_pixel(logic flush, logic [15:0] d);
      int                w, h, c, r, x, y;
      logic [15:0]       z, up1, up2;
      bit                have;
      pixel_verdict_type due;
      w = eff_width();
      h = eff_height();
      c = pos_col;
      r = pos_row;
      x = 0;
      y = 0;
      have = 1'b0;
      if (c >= w) begin
         c = 0;
         r++;
      end
      z = flush ? 16'd0 : d;
      up1 = line_a[c];
      up2 = line_b[c];
      line_b[c] = up1;
      line_a[c] = z;
      for (int k = 0; k < 3; k++) begin
         win[k*3]     = win[k*3 + 1];
         win[k*3 + 1] = win[k*3 + 2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = z;
      if (c >= 1) begin
         if (r >= 1) begin
            x = c - 1;
            y = r - 1;
            have = 1'b1;
         end
      end else if (r >= 2) begin
         x = w - 1;
         y = r - 2;
         have = 1'b1;
      end
      if (have && y >= h) have = 1'b0;
      // row past the flush row closes the frame
      if (r >= h + 1) begin
         pos_col = 0;
         pos_row = 0;
      end else begin
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         pos_col = c;
         pos_row = r;
      end
      if (have) begin
         due.verdict = judge_window(x, y, w, h);
         due.depth   = win[4];
         due.x       = dedge_pkg::COORD_BITS'(x);
         due.y       = dedge_pkg::COORD_BITS'(y);
         due.last    = (x == w - 1 && y == h - 1);
         verdicts_due.push_back(due);
      end
   endfunction

   // Requests still needed to bring the raster position back to frame start
   function automatic int steps_to_frame_start();
      int c, r, w, h, n;
      c = pos_col;
      r = pos_row;
      w = eff_width();
      h = eff_height();
      n = 0;
      if (c == 0 && r == 0) return 0;
      while (1'b1) begin
         n++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         if (r >= h + 1) return n;
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
      end
      return n;
   endfunction

   // Mostly smooth surfaces with steps, holes, saturation and range edges
   function automatic logic [15:0] pick_depth();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 16'd0;
      if (roll < 8) return 16'hFFFF;
      if (roll < 12) return 16'($urandom);
      if (roll < 16) begin
         case ($urandom_range(0, 3))
            0: return cfg_min - 16'd1;
            1: return cfg_min;
            2: return cfg_max;
            default: return cfg_max + 16'd1;
         endcase
      end
      if (roll < 30) surf_base = $urandom_range(200, 9000);
      return 16'(surf_base + $urandom_range(0, 40));
   endfunction

   task automatic write_reg(dedge_pkg::reg_index_type idx, int val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= 16'(val);
      case (idx)
         dedge_pkg::REG_DEPTH_MIN:    cfg_min    = 16'(val);
         dedge_pkg::REG_DEPTH_MAX:    cfg_max    = 16'(val);
         dedge_pkg::REG_EDGE_DELTA:   cfg_delta  = 16'(val);
         dedge_pkg::REG_EDGE_RATIO:   cfg_ratio  = 16'(val);
         dedge_pkg::REG_EDGE_MINN:    cfg_minn   = dedge_pkg::MINN_BITS'(val);
         dedge_pkg::REG_IMAGE_WIDTH:  cfg_width  = dedge_pkg::GEOM_BITS'(val);
         dedge_pkg::REG_IMAGE_HEIGHT: cfg_height = dedge_pkg::GEOM_BITS'(val);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_px(logic flush, logic [15:0] d);
      depth_req_type item;
      item.flush = flush;
      item.depth = d;
      pending_px.push_back(item);
      n_pushed++;
   endtask

   // Everything accepted, every verdict back, pipeline given time to empty
   task automatic wait_idle();
      while (n_accepted != n_pushed || verdicts_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Drain, then pad with flush ticks if the raster position is mid-frame
   task automatic settle();
      int fill;
      wait_idle();
      fill = steps_to_frame_start();
      if (fill > 0) begin
         repeat (fill) push_px(1'b1, 16'($urandom));
         wait_idle();
      end
   endtask

   task automatic send_frames(int frames, int early_pct);
      int w, h;
      w = eff_width();
      h = eff_height();
      @(negedge clock);
      repeat (frames) begin
         repeat (w * h) begin
            if ($urandom_range(0, 99) < early_pct) push_px(1'b1, 16'($urandom));
            else push_px(1'b0, pick_depth());
         end
         repeat (w + 1) push_px(1'b1, 16'($urandom));
      end
   endtask

   // Request driver: predicts on acceptance, random gap bursts between requests
   always @(posedge clock) begin : req_driver
      depth_req_type nxt;
      int            send_gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            filter_pixel(req_tuser[0], req_tdata);
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_px.size() > 0) begin
               nxt = pending_px[0];
               pending_px.delete(0);
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.depth;
               req_tuser  <= nxt.flush;
               if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each verdict, stalls in bursts, one long hold-off
   always @(posedge clock) begin : rsp_monitor
      pixel_verdict_type due;
      int                stall, hold_cnt;
      bit                hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall = 0;
         hold_cnt = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("unexpected result: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            end else begin
               due = verdicts_due[0];
               verdicts_due.delete(0);
               if (rsp_tdata[1:0] !== due.verdict || rsp_tdata[17:2] !== due.depth ||
                   rsp_tdata[28:18] !== due.x || rsp_tdata[39:29] !== due.y ||
                   rsp_tlast !== due.last) begin
                  n_bad++;
                  if (n_bad <= 10)
                     $display("mismatch: exp v%0d z%0d (%0d,%0d) l%b, got v%0d z%0d (%0d,%0d) l%b",
                              due.verdict, due.depth, due.x, due.y, due.last,
                              rsp_tdata[1:0], rsp_tdata[17:2], rsp_tdata[28:18],
                              rsp_tdata[39:29], rsp_tlast);
               end
            end
         end
         if (hold_req && !hold_done) begin
            hold_cnt = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 11) == 0) stall = $urandom_range(1, 17);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin : stimulus
      int phase, rand_start, keep, w, h;
      int vmin, vmax, vdelta, vratio, vminn, vw, vh;
      for (int i = 0; i < dedge_pkg::MAX_WIDTH_DEF; i++) begin
         line_a[i] = '0;
         line_b[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Full depth range, ratio near one, geometry below minimum saturates to 2x2
      write_reg(dedge_pkg::REG_DEPTH_MIN, 0);
      write_reg(dedge_pkg::REG_DEPTH_MAX, 16'hFFFF);
      write_reg(dedge_pkg::REG_EDGE_DELTA, 0);
      write_reg(dedge_pkg::REG_EDGE_RATIO, 16'hFFFF);
      write_reg(dedge_pkg::REG_EDGE_MINN, 1);
      write_reg(dedge_pkg::REG_IMAGE_WIDTH, 1);
      write_reg(dedge_pkg::REG_IMAGE_HEIGHT, 0);
      @(negedge clock);
      push_px(1'b0, 16'd0);
      push_px(1'b0, 16'hFFFF);
      push_px(1'b0, 16'd1);
      push_px(1'b0, 16'hFFFE);
      repeat (3) push_px(1'b1, 16'hFFFF);   // flush depth is ignored
      settle();

      // Empty range (min above max) and a flush tick inside the frame
      write_reg(dedge_pkg::REG_DEPTH_MIN, 5000);
      write_reg(dedge_pkg::REG_DEPTH_MAX, 10);
      write_reg(dedge_pkg::REG_EDGE_DELTA, 16'hFFFF);
      @(negedge clock);
      push_px(1'b0, 16'd6000);
      push_px(1'b1, 16'd7000);
      push_px(1'b0, 16'd7);
      push_px(1'b0, 16'hFFFF);
      repeat (3) push_px(1'b1, 16'd0);
      settle();

      // Neighbor minimum above nine never rejects
      write_reg(dedge_pkg::REG_DEPTH_MIN, 1);
      write_reg(dedge_pkg::REG_DEPTH_MAX, 16'hFFFF);
      write_reg(dedge_pkg::REG_EDGE_DELTA, 1);
      write_reg(dedge_pkg::REG_EDGE_RATIO, 0);
      write_reg(dedge_pkg::REG_EDGE_MINN, 15);
      @(negedge clock);
      push_px(1'b0, 16'd100);
      push_px(1'b0, 16'd5000);
      push_px(1'b0, 16'd100);
      push_px(1'b0, 16'd5000);
      repeat (3) push_px(1'b1, 16'd0);
      settle();

      // Random phases: new settings each time, whole frames with random content
      phase = 0;
      rand_start = n_pushed;
      while (n_pushed - rand_start < RANDOM_REQS) begin
         vmin = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 300);
         case ($urandom_range(0, 9))
            0:       vmax = 16'hFFFF;
            1:       vmax = $urandom_range(0, 99);
            default: vmax = $urandom_range(5000, 12000);
         endcase
         case ($urandom_range(0, 7))
            0, 1:    vdelta = 0;
            2:       vdelta = 16'hFFFF;
            default: vdelta = $urandom_range(1, 400);
         endcase
         case ($urandom_range(0, 7))
            0, 1:    vratio = 0;
            2:       vratio = 16'hFFFF;
            default: vratio = $urandom_range(1, 8000);
         endcase
         vminn = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
         case ($urandom_range(0, 19))
            0:       vw = $urandom_range(0, 1);
            1, 2:    vw = $urandom_range(17, 40);
            default: vw = $urandom_range(2, 16);
         endcase
         vh = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
         if (vw > 16) vh = $urandom_range(2, 3);
         if (phase == 0) begin
            vw = 12;
            vh = 6;
         end
         write_reg(dedge_pkg::REG_DEPTH_MIN, vmin);
         write_reg(dedge_pkg::REG_DEPTH_MAX, vmax);
         write_reg(dedge_pkg::REG_EDGE_DELTA, vdelta);
         write_reg(dedge_pkg::REG_EDGE_RATIO, vratio);
         write_reg(dedge_pkg::REG_EDGE_MINN, vminn);
         write_reg(dedge_pkg::REG_IMAGE_WIDTH, vw);
         write_reg(dedge_pkg::REG_IMAGE_HEIGHT, vh);
         if (n_pushed - rand_start > CALM_AFTER) idle_on <= 1'b0;
         else idle_on <= ($urandom_range(0, 3) != 0);
         // long receiver hold-off while requests keep coming
         if (phase == 0) hold_req <= 1'b1;
         w = eff_width();
         h = eff_height();
         if (phase == 4) begin
            // height and thresholds change partway into a frame
            @(negedge clock);
            keep = $urandom_range(w + 2, w * h);
            repeat (keep) push_px(1'b0, pick_depth());
            wait_idle();
            write_reg(dedge_pkg::REG_IMAGE_HEIGHT, $urandom_range(2, 8));
            write_reg(dedge_pkg::REG_EDGE_DELTA, 0);
            write_reg(dedge_pkg::REG_EDGE_RATIO, 0);
            @(negedge clock);
            repeat (w * h + w + 1 - keep) push_px(1'b0, pick_depth());
         end else begin
            send_frames($urandom_range(1, 3), ($urandom_range(0, 2) == 0) ? 4 : 0);
            // surplus flush ticks make a frame of invalid pixels
            if ($urandom_range(0, 5) == 0) repeat (w * h + w + 1) push_px(1'b1, 16'($urandom));
         end
         settle();
         phase++;
      end

      // Closing frames with no idling on either side
      idle_on <= 1'b0;
      write_reg(dedge_pkg::REG_IMAGE_WIDTH, 8);
      write_reg(dedge_pkg::REG_IMAGE_HEIGHT, 4);
      send_frames(2, 0);
      settle();

      if (n_bad == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
